@@ rtl/core/dfgn_pkg.sv @@
// ----------------------------------------------------------------------------
// dfgn_pkg
// Shared widths, codes and types of the depth frame to gray normalizer.
// ----------------------------------------------------------------------------
package dfgn_pkg;

  // Core sizing
  localparam int DEPTH_BITS = 16;
  localparam int COUNT_BITS = 20;
  localparam int HIST_SIZE  = 1 << DEPTH_BITS;
  localparam int CNT_W      = DEPTH_BITS + 1;
  localparam int NUM_W      = (COUNT_BITS > DEPTH_BITS) ? COUNT_BITS : DEPTH_BITS;

  // Port field widths
  localparam int IN_DEPTH_W = 16;
  localparam int GRAY_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Gray full scale is 2^shift - 1
  localparam int GRAY8_SHIFT  = 8;
  localparam int GRAY16_SHIFT = 16;
  localparam int DVD_W        = NUM_W + GRAY16_SHIFT;
  localparam int DIV_CNT_W    = $clog2(DVD_W + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIST_EQ = 8'd0,
    CFG_INVERT  = 8'd1,
    CFG_SHADOW  = 8'd2,
    CFG_WIDE    = 8'd3
  } cfg_idx_e;

  // Shadow mode bits: fill wins over black
  localparam int SHADOW_BLACK_BIT = 0;
  localparam int SHADOW_FILL_BIT  = 1;

  typedef struct packed {
    logic       hist_eq;
    logic       invert;
    logic [1:0] shadow;
    logic       wide;
  } cfg_t;

  // Classified request as queued between front and back
  typedef struct packed {
    logic                  gather;
    logic                  clear;
    logic                  build;
    logic                  row_start;
    logic                  nz;
    logic [DEPTH_BITS-1:0] depth;
  } cmd_t;

endpackage

@@ rtl/core/dfgn_if.sv @@
// ----------------------------------------------------------------------------
// dfgn_if
// Valid/ready channels of the normalizer: pixel input, gray output, config.
// ----------------------------------------------------------------------------
interface dfgn_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [dfgn_pkg::IN_DEPTH_W-1:0] depth;
  logic                          frame_start;
  logic                          row_start;
  logic                          last;

  modport source (output valid, mode, depth, frame_start, row_start, last, input ready);
  modport sink   (input valid, mode, depth, frame_start, row_start, last, output ready);
endinterface

interface dfgn_out_if;
  logic                        valid;
  logic                        ready;
  logic [dfgn_pkg::GRAY_W-1:0] gray_value;
  logic                        written;

  modport source (output valid, gray_value, written, input ready);
  modport sink   (input valid, gray_value, written, output ready);
endinterface

interface dfgn_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dfgn_pkg::CFG_IDX_W-1:0]  index;
  logic [dfgn_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/dfgn_ram.sv @@
// ----------------------------------------------------------------------------
// dfgn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dfgn_front.sv @@
// ----------------------------------------------------------------------------
// dfgn_front
// Accepts pixel requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module dfgn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  dfgn_in_if.sink          in_i,
  output logic             q_valid_o,
  output dfgn_pkg::cmd_t   q_data_o,
  input  logic             q_pop_i
);
  import dfgn_pkg::*;

  cmd_t              fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  cmd_t              cmd;
  logic              push, pop;

  // Classify: pass flags only count in their own pass
  always_comb begin
    cmd.gather    = ~in_i.mode;
    cmd.clear     = ~in_i.mode & in_i.frame_start;
    cmd.build     = ~in_i.mode & in_i.last;
    cmd.row_start = in_i.row_start;
    cmd.depth     = in_i.depth[DEPTH_BITS-1:0];
    cmd.nz        = (in_i.depth[DEPTH_BITS-1:0] != '0);
  end

  assign in_i.ready = (count_q != QCNT_W'(QDEPTH));
  assign push       = in_i.valid & in_i.ready;
  assign pop        = q_pop_i & q_valid_o;
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = fifo_q[rd_ptr_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

@@ rtl/core/dfgn_div.sv @@
// ----------------------------------------------------------------------------
// dfgn_div
// Restoring divider, one quotient bit per cycle, floor quotient.
// ----------------------------------------------------------------------------
module dfgn_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dfgn_pkg::DVD_W-1:0]     dividend_i,
  input  logic [dfgn_pkg::NUM_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [dfgn_pkg::GRAY_W-1:0]    quotient_o
);
  import dfgn_pkg::*;

  logic [DVD_W-1:0]     dvd_q;
  logic [NUM_W-1:0]     rem_q, den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [NUM_W:0]       trial, diff;
  logic                 ge;

  // One restoring step
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient never exceeds full scale
  assign done_o     = done_q;
  assign quotient_o = dvd_q[GRAY_W-1:0];

endmodule

@@ rtl/core/dfgn_back.sv @@
// ----------------------------------------------------------------------------
// dfgn_back
// Executes queued requests: histogram sweeps, gather updates, prefix pass,
// gray mapping and the output register.
// ----------------------------------------------------------------------------
module dfgn_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dfgn_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  dfgn_pkg::cmd_t   q_data_i,
  output logic             q_pop_o,
  dfgn_out_if.source       out_o
);
  import dfgn_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_GATHER, ST_PREFIX, ST_CONV, ST_DIV, ST_DONE
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  resume_q;
  cmd_t                  cur_q;
  logic [DEPTH_BITS-1:0] max_q, min_q;
  logic [COUNT_BITS-1:0] pcount_q, acc_q;
  logic                  cum_ready_q;
  logic [GRAY_W-1:0]     last_gray_q, res_q;
  logic                  res_wr_q, res_upd_q;
  logic                  out_valid_q, out_wr_q;
  logic [GRAY_W-1:0]     out_gray_q;

  // RAM ports
  logic                  rd_en, wr_en;
  logic [DEPTH_BITS-1:0] rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] wr_data, rdata;

  logic [COUNT_BITS:0]   psum;
  logic [COUNT_BITS-1:0] psum_sat, hist_inc, cnt_inc;
  logic                  out_free;

  // Mapping datapath
  logic [COUNT_BITS-1:0] c_cl;
  logic [DEPTH_BITS-1:0] d_cl;
  logic [NUM_W-1:0]      num, den;
  logic [DVD_W-1:0]      num_ext, dividend;
  logic                  span_empty;
  logic                  div_start, div_done;
  logic [GRAY_W-1:0]     quotient;

  dfgn_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (HIST_SIZE)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  dfgn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Saturating counts
  assign psum     = {1'b0, rdata} + {1'b0, acc_q};
  assign psum_sat = psum[COUNT_BITS] ? COUNT_MAX : psum[COUNT_BITS-1:0];
  assign hist_inc = (rdata == COUNT_MAX) ? COUNT_MAX : rdata + 1'b1;
  assign cnt_inc  = (pcount_q == COUNT_MAX) ? COUNT_MAX : pcount_q + 1'b1;

  assign q_pop_o  = (state_q == ST_IDLE) & q_valid_i;
  assign out_free = ~out_valid_q | out_o.ready;

  // Histogram port steering
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q.depth;
    wr_en   = 1'b0;
    wr_addr = cur_q.depth;
    wr_data = hist_inc;
    case (state_q)
      ST_IDLE: begin
        rd_en   = q_valid_i;
        rd_addr = q_data_i.depth;
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_GATHER: begin
        wr_en = cur_q.nz;
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[DEPTH_BITS-1:0];
        wr_data = '0;
      end
      ST_PREFIX: begin
        rd_en   = ~cnt_q[DEPTH_BITS];
        rd_addr = cnt_q[DEPTH_BITS-1:0];
        wr_en   = (cnt_q != '0);
        wr_addr = DEPTH_BITS'(cnt_q - 1'b1);
        wr_data = psum_sat;
      end
      default: ;
    endcase
  end

  // Numerator and denominator of the gray mapping
  always_comb begin
    c_cl = (rdata > pcount_q) ? pcount_q : rdata;
    d_cl = cur_q.depth;
    if (d_cl < min_q) d_cl = min_q;
    if (d_cl > max_q) d_cl = max_q;
    if (cfg_i.hist_eq) begin
      span_empty = ~cum_ready_q | (pcount_q == '0);
      num        = NUM_W'(cfg_i.invert ? pcount_q - c_cl : c_cl);
      den        = NUM_W'(pcount_q);
    end else begin
      span_empty = (max_q <= min_q);
      num        = NUM_W'(cfg_i.invert ? max_q - d_cl : d_cl - min_q);
      den        = NUM_W'(max_q - min_q);
    end
    num_ext  = DVD_W'(num);
    dividend = cfg_i.wide ? (num_ext << GRAY16_SHIFT) - num_ext
                          : (num_ext << GRAY8_SHIFT) - num_ext;
  end

  assign div_start = (state_q == ST_CONV) & cur_q.nz & ~span_empty;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      resume_q    <= 1'b0;
      cur_q       <= '0;
      max_q       <= '0;
      min_q       <= DEPTH_MAX;
      pcount_q    <= '0;
      acc_q       <= '0;
      cum_ready_q <= 1'b0;
      last_gray_q <= '0;
      res_q       <= '0;
      res_wr_q    <= 1'b0;
      res_upd_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_wr_q    <= 1'b0;
      out_gray_q  <= '0;
    end else begin
      // Output register: load a finished result, else drop on acceptance
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        // Zero sweep over the histogram
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(HIST_SIZE - 1)) begin
            state_q <= resume_q ? ST_READ : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            cur_q <= q_data_i;
            if (q_data_i.row_start) last_gray_q <= '0;
            if (q_data_i.clear) begin
              max_q       <= '0;
              min_q       <= DEPTH_MAX;
              pcount_q    <= '0;
              cum_ready_q <= 1'b0;
              cnt_q       <= '0;
              resume_q    <= 1'b1;
              state_q     <= ST_CLEAR;
            end else begin
              state_q <= q_data_i.gather ? ST_GATHER : ST_CONV;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_GATHER;
        end
        // Statistics update; histogram write in the same cycle
        ST_GATHER: begin
          if (cur_q.depth > max_q) max_q <= cur_q.depth;
          if (cur_q.nz) begin
            if (cur_q.depth < min_q) min_q <= cur_q.depth;
            pcount_q <= cnt_inc;
          end
          if (cur_q.build) begin
            cnt_q   <= '0;
            acc_q   <= '0;
            state_q <= ST_PREFIX;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        // Running sum: read entry i while writing entry i-1
        ST_PREFIX: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q != '0) acc_q <= psum_sat;
          if (cnt_q[DEPTH_BITS]) begin
            cum_ready_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_CONV: begin
          if (!cur_q.nz) begin
            res_q     <= cfg_i.shadow[SHADOW_FILL_BIT] ? last_gray_q : '0;
            res_wr_q  <= cfg_i.shadow[SHADOW_FILL_BIT] | cfg_i.shadow[SHADOW_BLACK_BIT];
            res_upd_q <= 1'b0;
            state_q   <= ST_DONE;
          end else if (span_empty) begin
            res_q     <= '0;
            res_wr_q  <= 1'b1;
            res_upd_q <= 1'b1;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_q     <= quotient;
            res_wr_q  <= 1'b1;
            res_upd_q <= 1'b1;
            state_q   <= ST_DONE;
          end
        end
        // Hand the result to the output register
        ST_DONE: begin
          if (out_free) begin
            out_gray_q  <= res_q;
            out_wr_q    <= res_wr_q;
            if (res_upd_q) last_gray_q <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.gray_value = out_gray_q;
  assign out_o.written    = out_wr_q;

endmodule

@@ rtl/core/depth_frame_to_gray_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// depth_frame_to_gray_normalizer_core
// Two-pass depth frame to gray converter with linear mapping or histogram equalization.
// ----------------------------------------------------------------------------
// Gather requests (mode 0) do a read-modify-write of their entry in the
// histogram RAM. A gather request with frame_start first runs a clearing
// pass over the histogram; the same clearing pass runs after reset, and
// requests wait until it ends. A gather request with last is followed by a
// prefix pass that turns the histogram into a cumulative one. Convert
// requests (mode 1) finish without division for a zero depth or an empty
// span, and otherwise go through the 36-step restoring divider. Results
// leave through an output register and the input side has a two-entry
// request queue, so either side may stall without the other.
// Configuration writes are always accepted.
module depth_frame_to_gray_normalizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfgn_in_if.sink    in_i,
  dfgn_out_if.source out_o,
  dfgn_cfg_if.sink   cfg_i
);
  import dfgn_pkg::*;

  cfg_t cfg_q;
  logic q_valid, q_pop;
  cmd_t q_data;

  // Register file
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HIST_EQ: cfg_q.hist_eq <= cfg_i.data[0];
        CFG_INVERT:  cfg_q.invert  <= cfg_i.data[0];
        CFG_SHADOW:  cfg_q.shadow  <= cfg_i.data[1:0];
        CFG_WIDE:    cfg_q.wide    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  dfgn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  dfgn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

@@ dv/tb_dfgn_checker.sv @@
// ----------------------------------------------------------------------------
// tb_dfgn_checker
// Watches the pixel, gray and register channels of the normalizer, keeps its
// own copy of the frame statistics and settings, predicts the gray result
// of every convert request and compares each one in arrival order.
// ----------------------------------------------------------------------------
module tb_dfgn_checker
  import dfgn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dfgn_in_if   pix_i,
  dfgn_out_if  gray_i,
  dfgn_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   gray_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [GRAY_W-1:0] gray_value;
    logic              written;
  } gray_res_t;

  // Frame statistics and settings as the block should hold them
  logic [COUNT_BITS-1:0] depth_hist [HIST_SIZE];
  logic [DEPTH_BITS-1:0] max_depth, min_depth;
  logic [COUNT_BITS-1:0] nz_count;
  logic [GRAY_W-1:0]     row_gray;
  logic                  cum_valid;
  cfg_t                  cfg;
  gray_res_t             gray_q [$];

  function automatic logic [COUNT_BITS-1:0] count_up(logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void clear_frame();
    foreach (depth_hist[i]) depth_hist[i] = '0;
    max_depth = '0;
    min_depth = DEPTH_MAX;
    nz_count  = '0;
    cum_valid = 1'b0;
  endfunction

  // Running sum over the histogram, saturating
  function automatic void build_cumulative();
    longint unsigned s;
    for (int i = 1; i < HIST_SIZE; i++) begin
      s = longint'(depth_hist[i]) + longint'(depth_hist[i-1]);
      depth_hist[i] = (s > COUNT_MAX) ? COUNT_MAX : s[COUNT_BITS-1:0];
    end
    cum_valid = 1'b1;
  endfunction

  function automatic logic [GRAY_W-1:0] depth_to_gray(logic [DEPTH_BITS-1:0] d);
    longint unsigned full, num, den, c, n, lo, hi, dd;
    full = cfg.wide ? 65535 : 255;
    if (cfg.hist_eq) begin
      n = nz_count;
      if (!cum_valid || n == 0) return '0;
      c = depth_hist[d];
      if (c > n) c = n;
      num = cfg.invert ? n - c : c;
      den = n;
    end else begin
      lo = min_depth;
      hi = max_depth;
      dd = d;
      if (hi <= lo) return '0;
      if (dd < lo) dd = lo;
      if (dd > hi) dd = hi;
      num = cfg.invert ? hi - dd : dd - lo;
      den = hi - lo;
    end
    return GRAY_W'((num * full) / den);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gray_res_t exp_r;
    logic [DEPTH_BITS-1:0] d;
    if (!rst_ni) begin
      clear_frame();
      row_gray = '0;
      cfg = '0;
      gray_q.delete();
      fail_count_o = 0;
    end else begin
      // Result side first: it can only answer older requests
      if (gray_i.valid && gray_i.ready) begin
        if (gray_q.size() == 0) begin
          $error("gray result with no request waiting: gray_value=%0d written=%0b",
                 gray_i.gray_value, gray_i.written);
          fail_count_o++;
        end else begin
          exp_r = gray_q.pop_front();
          if (gray_i.gray_value !== exp_r.gray_value) begin
            $error("gray_value: expected %0d, actual %0d", exp_r.gray_value,
                   gray_i.gray_value);
            fail_count_o++;
          end
          if (gray_i.written !== exp_r.written) begin
            $error("written: expected %0b, actual %0b", exp_r.written, gray_i.written);
            fail_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_HIST_EQ: cfg.hist_eq = cfg_i.data[0];
          CFG_INVERT:  cfg.invert  = cfg_i.data[0];
          CFG_SHADOW:  cfg.shadow  = cfg_i.data[1:0];
          CFG_WIDE:    cfg.wide    = cfg_i.data[0];
          default: ;
        endcase
      end
      if (pix_i.valid && pix_i.ready) begin
        d = pix_i.depth[DEPTH_BITS-1:0];
        if (pix_i.row_start) row_gray = '0;
        if (!pix_i.mode) begin
          // Gather pass
          if (pix_i.frame_start) clear_frame();
          if (d > max_depth) max_depth = d;
          if (d != 0) begin
            if (d < min_depth) min_depth = d;
            depth_hist[d] = count_up(depth_hist[d]);
            nz_count = count_up(nz_count);
          end
          if (pix_i.last) build_cumulative();
        end else begin
          // Convert pass; fill wins over black for zero depth
          if (d != 0) begin
            row_gray = depth_to_gray(d);
            exp_r = '{row_gray, 1'b1};
          end else if (cfg.shadow[SHADOW_FILL_BIT]) begin
            exp_r = '{row_gray, 1'b1};
          end else if (cfg.shadow[SHADOW_BLACK_BIT]) begin
            exp_r = '{'0, 1'b1};
          end else begin
            exp_r = '{'0, 1'b0};
          end
          gray_q.push_back(exp_r);
        end
      end
    end
    gray_pending_o = gray_q.size();
  end

endmodule

@@ dv/tb_depth_frame_to_gray_normalizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_depth_frame_to_gray_normalizer_core
// Drives whole frames through the normalizer: a gather pass, then convert
// passes under several register settings, with random gaps on both sides,
// a long output stall and a drain pause. A checker module compares results.
// ----------------------------------------------------------------------------
module tb_depth_frame_to_gray_normalizer_core;
  import dfgn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i, rst_ni;
  int   fail_count, gray_pending;
  int   idle_pct = 22;
  int   hold_req_n = 0;
  int   frames_run = 0, pixels_sent = 0;
  logic [DEPTH_BITS-1:0] seen_depths [$];

  dfgn_in_if  pix_if ();
  dfgn_out_if gray_if ();
  dfgn_cfg_if cfg_if ();

  depth_frame_to_gray_normalizer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .out_o  (gray_if),
    .cfg_i  (cfg_if)
  );

  tb_dfgn_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_i          (pix_if),
    .gray_i         (gray_if),
    .cfg_i          (cfg_if),
    .fail_count_o   (fail_count),
    .gray_pending_o (gray_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit: each frame costs about two full passes over the histogram table
  initial begin
    #200_000_000;
    $display("tb_depth_frame_to_gray_normalizer_core: FAIL");
    $finish;
  end

  // Gray receiver: random back-pressure, plus long holds on request
  initial begin
    int hold_done_n;
    hold_done_n = 0;
    gray_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req_n != hold_done_n) begin
        hold_done_n = hold_req_n;
        gray_if.ready = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      gray_if.ready = ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.index = idx;
    cfg_if.data  = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_regs(bit heq, bit inv, logic [1:0] shd, bit wide);
    write_reg(CFG_HIST_EQ, CFG_DATA_W'(heq));
    write_reg(CFG_INVERT, CFG_DATA_W'(inv));
    write_reg(CFG_SHADOW, CFG_DATA_W'(shd));
    write_reg(CFG_WIDE, CFG_DATA_W'(wide));
  endtask

  // One pixel request; called at a falling edge, returns at a falling edge
  task automatic send_pixel(bit mode, logic [15:0] depth, bit fs, bit rs, bit lst);
    while ($urandom_range(99) < idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_if.mode        = mode;
    pix_if.depth       = depth;
    pix_if.frame_start = fs;
    pix_if.row_start   = rs;
    pix_if.last        = lst;
    pix_if.valid       = 1'b1;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
    if (!mode && depth != 0) seen_depths.push_back(depth);
    @(negedge clk_i);
  endtask

  // Wait until every gray result is in, then let the block settle
  task automatic drain();
    pix_if.valid = 1'b0;
    while (gray_pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  // Let a clearing pass and a prefix pass finish before registers change
  task automatic settle_tables();
    repeat (2 * HIST_SIZE + 256) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_depth(int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return '0;
    if (r < zero_pct + 10 || seen_depths.size() == 0) return 16'($urandom_range(65535));
    return 16'(seen_depths[$urandom_range(seen_depths.size() - 1)] + $urandom_range(2) - 1);
  endfunction

  task automatic gather_frame(int n, bit clear_first, bit narrow);
    logic [15:0] base, d;
    base = 16'($urandom_range(60000));
    if (clear_first) seen_depths.delete();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) d = '0;
      else if (narrow) d = 16'(base + $urandom_range(300));
      else d = 16'($urandom_range(65535));
      send_pixel(1'b0, d, clear_first && i == 0, $urandom_range(99) < 10, i == n - 1);
    end
    frames_run++;
  endtask

  task automatic convert_run(int n);
    for (int i = 0; i < n; i++)
      send_pixel(1'b1, pick_depth(20), $urandom_range(99) < 5,
                 $urandom_range(99) < 12, $urandom_range(99) < 5);
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.mode = 1'b0;
    pix_if.depth = '0;
    pix_if.frame_start = 1'b0;
    pix_if.row_start = 1'b0;
    pix_if.last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: equalization before any table exists, shadow codes 1 and 3
    set_regs(1'b1, 1'b0, 2'd1, 1'b0);
    send_pixel(1'b1, 16'd1000, 1'b0, 1'b1, 1'b0);
    send_pixel(1'b1, 16'd0, 1'b1, 1'b0, 1'b1);
    drain();
    write_reg(CFG_SHADOW, CFG_DATA_W'(3));
    send_pixel(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
    drain();

    // Directed: frame with a single nonzero depth, so the linear span is empty
    gather_frame(0, 1'b1, 1'b0);
    send_pixel(1'b0, 16'd500, 1'b1, 1'b1, 1'b0);
    send_pixel(1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
    send_pixel(1'b0, 16'd500, 1'b0, 1'b0, 1'b1);
    drain();
    settle_tables();
    set_regs(1'b0, 1'b0, 2'd2, 1'b1);
    send_pixel(1'b1, 16'd500, 1'b0, 1'b1, 1'b0);
    send_pixel(1'b1, 16'd65535, 1'b0, 1'b0, 1'b0);
    drain();
    // Equalization on it, clamped above the gathered range, inverted
    set_regs(1'b1, 1'b1, 2'd0, 1'b0);
    send_pixel(1'b1, 16'd1, 1'b0, 1'b0, 1'b0);
    send_pixel(1'b1, 16'd500, 1'b0, 1'b0, 1'b0);
    send_pixel(1'b1, 16'd65535, 1'b0, 1'b0, 1'b0);
    send_pixel(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
    drain();

    // Directed: full-range frame with both extreme depths
    send_pixel(1'b0, 16'd1, 1'b1, 1'b0, 1'b0);
    send_pixel(1'b0, 16'd65535, 1'b0, 1'b0, 1'b0);
    send_pixel(1'b0, 16'd32768, 1'b0, 1'b0, 1'b1);
    drain();
    settle_tables();
    set_regs(1'b0, 1'b1, 2'd1, 1'b1);
    send_pixel(1'b1, 16'd65535, 1'b0, 1'b0, 1'b0);
    send_pixel(1'b1, 16'd1, 1'b0, 1'b0, 1'b0);
    send_pixel(1'b1, 16'd0, 1'b0, 1'b1, 1'b0);
    drain();

    // Random frames, one of them piling onto the previous table
    for (int f = 0; f < 4; f++) begin
      gather_frame($urandom_range(20, 40), f != 2, bit'($urandom_range(1)));
      drain();
      settle_tables();
      for (int p = 0; p < 3; p++) begin
        set_regs(bit'($urandom_range(1)), bit'($urandom_range(1)),
                 2'($urandom_range(3)), bit'($urandom_range(1)));
        if (f == 1 && p == 0) begin
          idle_pct = 0;
          convert_run(40);
          idle_pct = 22;
        end else if (f == 2 && p == 1) begin
          hold_req_n++;
          convert_run(35);
        end else begin
          convert_run(33);
        end
        drain();
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    $display("Ran %0d frames, %0d pixel requests, linear and equalized mappings,",
             frames_run, pixels_sent);
    $display("all shadow codes, both gray widths, stalls and a drained pause.");
    if (fail_count == 0) begin
      $display("tb_depth_frame_to_gray_normalizer_core: PASS");
    end else begin
      $display("tb_depth_frame_to_gray_normalizer_core: FAIL");
    end
    $finish;
  end

endmodule
